// File: sv/hsvrgb_pkg.sv
package hsvrgb_pkg;

	// hue codes: 128 per degree
	localparam logic [15:0] HUE_FULL_TURN = 16'd46080;
	localparam int          REM_W         = 13;
	localparam logic [REM_W-1:0] HUE_SECTOR = 13'd7680;

	// q1.15 unity
	localparam int          CH_W    = 16;
	localparam logic [CH_W-1:0] Q15_ONE = 16'd32768;

	// s * weight, at most 32768 * 7680 < 2**28
	localparam int PROD_W = 28;

	// divide by 7680 = shift by 9, then multiply by ceil(2**23 / 15)
	localparam int          DIV_SHIFT   = 9;
	localparam int          QUO_IN_W    = PROD_W - DIV_SHIFT;
	localparam int          RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 20'd559241;
	localparam int          RECIP_SHIFT = 23;
	localparam int          RECIP_PROD_W = QUO_IN_W + RECIP_W;

	// v times a q1.15 factor, below 2**31
	localparam int SCALE_W = 31;

	// 60 degree sectors
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	// load enables for the fraction scaling stages
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

// File: sv/hsv_to_rgb_converter_top.sv
// HSV to RGB converter. Takes one item per clock while in_stall is low (hue in 1/128
// degree, saturation and value in Q1.15) and returns red, green and blue in Q1.15. The
// five register stages are: sector split, saturation products, divide by 7680 through a
// reciprocal multiply, value products, and the channel select that feeds the output
// register. Each stage loads whenever it is empty or the next one moves, so bubbles close
// up and in_stall rises only when all five stages hold items and the output is stalled.
module hsv_to_rgb_converter_top
	import hsvrgb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [CH_W-1:0] hue,
	input  logic [CH_W-1:0] saturation,
	input  logic [CH_W-1:0] brightness,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [CH_W-1:0] red,
	output logic [CH_W-1:0] green,
	output logic [CH_W-1:0] blue
);

	logic en1, en2, en3, en4, en5;
	stage_en_t frac_en;

	// stage 1 signals
	logic [CH_W-1:0]  hue_w, sec_base, sat_c, val_c;
	sector_t          sec_c;
	logic             valid_s1;
	logic [CH_W-1:0]  sat_s1, val_s1;
	sector_t          sec_s1;
	logic [REM_W-1:0] rem_s1;

	// stage 2 signals
	logic             valid_s2;
	logic [CH_W-1:0]  sat_s2, val_s2;
	sector_t          sec_s2;
	logic [SCALE_W-1:0] p_prod_s2;

	// stage 3 signals
	logic             valid_s3;
	logic [CH_W-1:0]  sat_s3, val_s3, p_s3, sf_s3, sfc_s3;
	sector_t          sec_s3;

	// stage 4 signals
	logic             valid_s4, grey_s4;
	logic [CH_W-1:0]  val_s4, p_s4;
	sector_t          sec_s4;
	logic [SCALE_W-1:0] q_prod_s4, t_prod_s4;

	// stage 5 signals
	logic             valid_s5;
	logic [CH_W-1:0]  q_w, t_w, red_w, green_w, blue_w;
	logic [CH_W-1:0]  red_s5, green_s5, blue_s5;

	// stage load enables, each stage moves when empty or the next one moves
	assign en5 = !valid_s5 || !out_stall;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_stall = !en1;
	assign frac_en = '{s2: en2, s3: en3};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
		end
	end

	// clamp inputs, zero a hue of a full turn or more, split into sector and remainder
	always_comb begin
		sat_c = (saturation > Q15_ONE) ? Q15_ONE : saturation;
		val_c = (brightness > Q15_ONE) ? Q15_ONE : brightness;
		hue_w = (hue >= HUE_FULL_TURN) ? '0 : hue;
		if (hue_w < CH_W'(HUE_SECTOR)) begin
			sec_c = SEC_R_TO_Y;
			sec_base = '0;
		end else if (hue_w < CH_W'(2 * HUE_SECTOR)) begin
			sec_c = SEC_Y_TO_G;
			sec_base = CH_W'(HUE_SECTOR);
		end else if (hue_w < CH_W'(3 * HUE_SECTOR)) begin
			sec_c = SEC_G_TO_C;
			sec_base = CH_W'(2 * HUE_SECTOR);
		end else if (hue_w < CH_W'(4 * HUE_SECTOR)) begin
			sec_c = SEC_C_TO_B;
			sec_base = CH_W'(3 * HUE_SECTOR);
		end else if (hue_w < CH_W'(5 * HUE_SECTOR)) begin
			sec_c = SEC_B_TO_M;
			sec_base = CH_W'(4 * HUE_SECTOR);
		end else begin
			sec_c = SEC_M_TO_R;
			sec_base = CH_W'(5 * HUE_SECTOR);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sat_s1 <= sat_c;
			val_s1 <= val_c;
			sec_s1 <= sec_c;
			rem_s1 <= REM_W'(hue_w - sec_base);
		end
	end

	// p product; the sf and sfc products live in the fraction units
	always_ff @(posedge clk) begin
		if (en2) begin
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
			sec_s2    <= sec_s1;
			p_prod_s2 <= SCALE_W'(val_s1) * SCALE_W'(Q15_ONE - sat_s1);
		end
	end

	// s times fraction and s times one minus fraction, divided by 7680
	hsvrgb_frac_scale u_sf (
		.clk     (clk),
		.en      (frac_en),
		.sat     (sat_s1),
		.weight  (rem_s1),
		.frac_s3 (sf_s3)
	);

	hsvrgb_frac_scale u_sfc (
		.clk     (clk),
		.en      (frac_en),
		.sat     (sat_s1),
		.weight  (HUE_SECTOR - rem_s1),
		.frac_s3 (sfc_s3)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			sat_s3 <= sat_s2;
			val_s3 <= val_s2;
			sec_s3 <= sec_s2;
			p_s3   <= p_prod_s2[CH_W+14:15];
		end
	end

	// q and t products
	always_ff @(posedge clk) begin
		if (en4) begin
			grey_s4   <= (sat_s3 == '0);
			val_s4    <= val_s3;
			sec_s4    <= sec_s3;
			p_s4      <= p_s3;
			q_prod_s4 <= SCALE_W'(val_s3) * SCALE_W'(Q15_ONE - sf_s3);
			t_prod_s4 <= SCALE_W'(val_s3) * SCALE_W'(Q15_ONE - sfc_s3);
		end
	end

	// place v, p, q, t by sector, grey when saturation is zero
	always_comb begin
		q_w = q_prod_s4[CH_W+14:15];
		t_w = t_prod_s4[CH_W+14:15];
		case (sec_s4)
			SEC_R_TO_Y: begin red_w = val_s4; green_w = t_w;    blue_w = p_s4;   end
			SEC_Y_TO_G: begin red_w = q_w;    green_w = val_s4; blue_w = p_s4;   end
			SEC_G_TO_C: begin red_w = p_s4;   green_w = val_s4; blue_w = t_w;    end
			SEC_C_TO_B: begin red_w = p_s4;   green_w = q_w;    blue_w = val_s4; end
			SEC_B_TO_M: begin red_w = t_w;    green_w = p_s4;   blue_w = val_s4; end
			default:    begin red_w = val_s4; green_w = p_s4;   blue_w = q_w;    end
		endcase
		if (grey_s4) begin
			red_w   = val_s4;
			green_w = val_s4;
			blue_w  = val_s4;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= red_w;
			green_s5 <= green_w;
			blue_s5  <= blue_w;
		end
	end

	assign out_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

	// input only held back while the output is stalled
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with the output free");

	// hue remainder stays within one sector
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (rem_s1 < HUE_SECTOR))
		else $error("hue remainder out of range");

	// the two truncated fractions add up to s or s - 1
	a_frac_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ((CH_W+1)'(sf_s3) + (CH_W+1)'(sfc_s3) == (CH_W+1)'(sat_s3) ||
			(CH_W+1)'(sf_s3) + (CH_W+1)'(sfc_s3) + 1'b1 == (CH_W+1)'(sat_s3)))
		else $error("fraction split does not match saturation");

	// channels never exceed one
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= Q15_ONE && green <= Q15_ONE && blue <= Q15_ONE))
		else $error("channel above unity");

endmodule

// File: sv/hsvrgb_frac_scale.sv
module hsvrgb_frac_scale
	import hsvrgb_pkg::*;
(
	input  logic             clk,
	input  stage_en_t        en,
	input  logic [CH_W-1:0]  sat,
	input  logic [REM_W-1:0] weight,
	output logic [CH_W-1:0]  frac_s3
);

	logic [PROD_W-1:0]       prod_s2;
	logic [RECIP_PROD_W-1:0] quot_full;

	// s times sector weight
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PROD_W'(sat) * PROD_W'(weight);
		end
	end

	// divide by 7680: drop 9 bits, then divide by 15 through the reciprocal
	assign quot_full = RECIP_PROD_W'(prod_s2[PROD_W-1:DIV_SHIFT]) * RECIP_PROD_W'(RECIP_MUL);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			frac_s3 <= quot_full[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
		end
	end

endmodule
